// ===== src/cl3_multivector_product_assert.svh =====
// Assertion macros for the Cl(3,0) product block
`ifndef CL3_MULTIVECTOR_PRODUCT_ASSERT_SVH
`define CL3_MULTIVECTOR_PRODUCT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock outside reset
`define CL3_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock outside reset
`define CL3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cl3mvp_pkg.sv =====
package cl3mvp_pkg;

   // Operand and sum widths
   localparam int CompWidth   = 16;
   localparam int ProdWidth   = 2 * CompWidth;
   localparam int ResWidth    = 35;
   localparam int IndexWidth  = 3;
   localparam int OpWidth     = 2;
   localparam int ReqDataBits = IndexWidth + 2 * CompWidth;
   localparam int ReqDataWidth = ((ReqDataBits + 7) / 8) * 8;
   localparam int RspDataBits = IndexWidth + ResWidth;
   localparam int RspDataWidth = ((RspDataBits + 7) / 8) * 8;

   typedef logic [IndexWidth-1:0] blade_type;

   typedef enum logic [OpWidth-1:0] {
      OP_GEOMETRIC = 2'd0,
      OP_OUTER     = 2'd1,
      OP_LEFT_CONT = 2'd2,
      OP_SCALAR    = 2'd3
   } op_type;

   // Blade index <-> basis bit mask; the mapping is its own inverse
   function automatic blade_type blade_mask(input blade_type idx);
      blade_type m;
      case (idx)
         3'd0:    m = 3'd0;
         3'd1:    m = 3'd1;
         3'd2:    m = 3'd2;
         3'd3:    m = 3'd4;
         3'd4:    m = 3'd3;
         3'd5:    m = 3'd5;
         3'd6:    m = 3'd6;
         default: m = 3'd7;
      endcase
      return m;
   endfunction

   function automatic logic [1:0] grade_of(input blade_type m);
      return 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
   endfunction

   // Odd number of swaps to bring ma*mb into canonical order flips the sign
   function automatic logic product_negative(input blade_type ma, input blade_type mb);
      logic par;
      par = 1'b0;
      for (int b = 0; b < 3; b++) begin
         if (ma[b]) begin
            par = par ^ (^(mb & blade_type'((1 << b) - 1)));
         end
      end
      return par;
   endfunction

   // Grade filter of each product kind
   function automatic logic term_kept(input op_type op, input blade_type ma,
                                      input blade_type mb);
      logic [1:0] ga;
      logic [1:0] gb;
      logic [1:0] gc;
      logic       keep;
      ga = grade_of(ma);
      gb = grade_of(mb);
      gc = grade_of(ma ^ mb);
      case (op)
         OP_OUTER:     keep = ({1'b0, gc} == ({1'b0, ga} + {1'b0, gb}));
         OP_LEFT_CONT: keep = (ga <= gb) && (gc == gb - ga);
         default:      keep = 1'b1;
      endcase
      return keep;
   endfunction

endpackage

// ===== src/cl3_multivector_product.sv =====
// Channel | Dir | Beat contents
// req_    | in  | tdata: component_index, a_component, b_component; tuser: operation;
//         |     | tlast: last_component (starts the product)
// rsp_    | out | tdata: result_index, result_value; tlast: result_last
//
// One shared multiplier feeds one accumulator; result blades are worked one at a time.
// Per result blade: a multiply pass over all eight terms, a drain state, then the output
// beat. A full product gives all eight result blades, a scalar product only blade 0.
// Loading beats are taken while idle; req_tready is low from a tlast beat until the
// final result beat is taken. Reset (synchronous) zeroes both operand stores.
// A low rsp_tready holds the result beat and the whole sequencer.
module cl3_multivector_product
   import cl3mvp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [2:0] component_index, [18:3] a_component, [34:19] b_component, rest zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   // [1:0] operation
   input  logic [OpWidth-1:0]      req_tuser,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [2:0] result_index, [37:3] result_value, rest zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tlast
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MAC   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   op_type                       op_ff, op_in;
   blade_type                    i_ff, i_in;
   blade_type                    k_ff, k_in;
   logic signed [CompWidth-1:0]  a_store_ff [8];
   logic signed [CompWidth-1:0]  b_store_ff [8];
   logic signed [ProdWidth-1:0]  prod_ff;
   logic                         neg_ff;
   logic                         keep_ff;
   logic                         term_vld_ff, term_vld_in;
   logic signed [ResWidth-1:0]   acc_ff, acc_in;
   logic signed [ResWidth-1:0]   term_ext;

   logic                         req_beat;
   logic                         rsp_beat;
   blade_type                    req_index;
   blade_type                    ma, mb, j_idx;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;
   assign req_index = req_tdata[IndexWidth-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = (k_ff == blade_type'(7)) || (op_ff == OP_SCALAR);
   assign rsp_tdata  = RspDataWidth'({acc_ff, k_ff});

   // Pick the right-hand blade that lands on result blade k
   assign ma    = blade_mask(i_ff);
   assign mb    = ma ^ blade_mask(k_ff);
   assign j_idx = blade_mask(mb);

   // Store operand pairs on every loading beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 8; n++) begin
            a_store_ff[n] <= '0;
            b_store_ff[n] <= '0;
         end
      end else if (req_beat) begin
         a_store_ff[req_index] <= req_tdata[IndexWidth +: CompWidth];
         b_store_ff[req_index] <= req_tdata[IndexWidth + CompWidth +: CompWidth];
      end
   end

   // Multiply stage: one term per cycle while the sequencer is in S_MAC
   always_ff @(posedge clock) begin
      prod_ff <= a_store_ff[i_ff] * b_store_ff[j_idx];
      neg_ff  <= product_negative(ma, mb);
      keep_ff <= term_kept(op_ff, ma, mb);
   end

   assign term_ext = ResWidth'(prod_ff);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      term_vld_in = 1'b0;
      if (term_vld_ff && keep_ff) begin
         acc_in = neg_ff ? (acc_ff - term_ext) : (acc_ff + term_ext);
      end
      case (state_ff)
         S_IDLE: begin
            if (req_beat && req_tlast) begin
               op_in    = op_type'(req_tuser);
               i_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            term_vld_in = 1'b1;
            i_in        = i_ff + 1'b1;
            if (i_ff == blade_type'(7)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_beat) begin
               if (rsp_tlast) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  i_in     = '0;
                  acc_in   = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         op_ff       <= OP_GEOMETRIC;
         term_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         op_ff       <= op_in;
         term_vld_ff <= term_vld_in;
      end
   end

   // Counters and accumulator
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      k_ff   <= k_in;
      acc_ff <= acc_in;
   end

`include "cl3_multivector_product_assert.svh"

   `CL3_ASSERT_NOW(a_no_overlap, rsp_tvalid, !req_tready, "input taken while a result is pending")
   `CL3_ASSERT_NOW(a_scalar_single, rsp_tvalid && (op_ff == OP_SCALAR), rsp_tlast && (k_ff == '0), "scalar product must give one beat for blade 0")
   `CL3_ASSERT_NEXT(a_start, req_beat && req_tlast, (state_ff == S_MAC) && (i_ff == '0) && (k_ff == '0), "tlast beat did not start the product")
   `CL3_ASSERT_NEXT(a_next_blade, rsp_beat && !rsp_tlast, (state_ff == S_MAC) && (i_ff == '0) && (acc_ff == '0), "next result blade did not restart cleanly")

endmodule
